### rtl/core/chunked_payload_deframer_assert.svh
// Assertion macros for the chunked payload deframer.
// Expect aclk and aresetn in the scope of use.
`ifndef CHUNKED_PAYLOAD_DEFRAMER_ASSERT_SVH
`define CHUNKED_PAYLOAD_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define CPD_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication
`define CPD_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

### rtl/core/cpd_pkg.sv
// Shared types and constants of the chunked payload deframer.
// No dependencies.
`default_nettype none

package cpd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;
    localparam int Q_DEPTH = 2;

    localparam logic [7:0] CR_BYTE  = 8'h0D;
    localparam logic [7:0] LF_BYTE  = 8'h0A;
    localparam logic [7:0] EXT_MARK = 8'h3B;

    localparam logic [2:0] PH_HDR_START = 3'd0;
    localparam logic [2:0] PH_HDR       = 3'd1;
    localparam logic [2:0] PH_DATA      = 3'd2;
    localparam logic [2:0] PH_TRAIL_CR  = 3'd3;
    localparam logic [2:0] PH_TRAIL_LF  = 3'd4;

    localparam logic [2:0] OC_PENDING   = 3'd0;
    localparam logic [2:0] OC_COMPLETE  = 3'd1;
    localparam logic [2:0] OC_MALFORMED = 3'd2;
    localparam logic [2:0] OC_INVALID   = 3'd3;
    localparam logic [2:0] OC_TRUNCATED = 3'd4;
    localparam logic [2:0] OC_NO_TERM   = 3'd5;

    typedef struct packed {
        logic [7:0] data;
        logic       body_end;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
        logic       is_semi;
    } item_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       finished;
    } back_status_t;

endpackage

`default_nettype wire

### rtl/core/chunked_payload_deframer.sv
// Top level of the chunked payload deframer: front classifier, item queue, back FSM.
// Depends on cpd_pkg, cpd_front, cpd_queue, cpd_back and the assertion header.
//
// Channel | Direction | tdata (low bit up)                        | tlast    | tuser
// s_axis  | in        | data_in[7:0]                              | body_end | -
// m_axis  | out       | payload_byte[7:0], outcome[10:8], zero pad | -        | payload_valid
//
// One item per clock sustained while m_axis_tready holds; the back FSM updates its state on each popped item.
// An accepted item passes through a queue entry and the registered result stage before its result is on m_axis.
// Reset (aresetn low, synchronous) empties the queue and returns to a chunk header.
// A two-entry queue lets s_axis keep flowing until the queue is full while m_axis stalls.
`default_nettype none

module chunked_payload_deframer #(
    parameter int SIZE_BITS = cpd_pkg::SIZE_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_in
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // payload_byte, outcome, pad
    output logic             m_axis_tuser    // payload_valid
);
    import cpd_pkg::*;

    `include "chunked_payload_deframer_assert.svh"

    logic         push;
    item_t        push_item;
    logic         queue_full;
    logic         pop;
    item_t        head_item;
    logic         queue_empty;
    back_status_t back_status;

    cpd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    cpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head_item (head_item),
        .empty     (queue_empty)
    );

    cpd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_item     (head_item),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .status        (back_status)
    );

    `CPD_CHECK(a_idle_byte_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'd0)
    `CPD_CHECK(a_outcome_range, m_axis_tvalid, m_axis_tdata[10:8] <= OC_NO_TERM)
    `CPD_CHECK_NEXT(a_item_held, s_axis_tvalid && s_axis_tready, m_axis_tvalid || !queue_empty)
    `CPD_CHECK(a_finished_idle, back_status.finished, back_status.phase != PH_DATA)

endmodule

`default_nettype wire

### rtl/core/cpd_queue.sv
// Two-entry item queue between the front and back parts.
// Depends on cpd_pkg.
`default_nettype none

module cpd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  cpd_pkg::item_t     push_item,
    output logic               full,
    input  wire logic          pop,
    output cpd_pkg::item_t     head_item,
    output logic               empty
);
    import cpd_pkg::*;

    localparam int PTR_BITS = $clog2(Q_DEPTH);

    item_t                entry_reg [Q_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]    count_reg, count_next;

    assign full      = (count_reg == (PTR_BITS+1)'(Q_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cpd_front.sv
// Front part: accepts body bytes and classifies them for the back part.
// Depends on cpd_pkg.
`default_nettype none

module cpd_front (
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        queue_full,
    output logic             push,
    output cpd_pkg::item_t   push_item
);
    import cpd_pkg::*;

    logic       digit_num;
    logic       digit_upper;
    logic       digit_lower;
    logic [7:0] hex_raw;

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    assign digit_num   = (s_axis_tdata >= 8'h30) && (s_axis_tdata <= 8'h39);
    assign digit_upper = (s_axis_tdata >= 8'h41) && (s_axis_tdata <= 8'h46);
    assign digit_lower = (s_axis_tdata >= 8'h61) && (s_axis_tdata <= 8'h66);

    always_comb begin
        if (digit_upper) begin
            hex_raw = s_axis_tdata - 8'h37;
        end else if (digit_lower) begin
            hex_raw = s_axis_tdata - 8'h57;
        end else begin
            hex_raw = s_axis_tdata - 8'h30;
        end
    end

    always_comb begin
        push_item.data     = s_axis_tdata;
        push_item.body_end = s_axis_tlast;
        push_item.is_hex   = digit_num || digit_upper || digit_lower;
        push_item.hex_val  = hex_raw[3:0];
        push_item.is_cr    = (s_axis_tdata == CR_BYTE);
        push_item.is_lf    = (s_axis_tdata == LF_BYTE);
        push_item.is_semi  = (s_axis_tdata == EXT_MARK);
    end

endmodule

`default_nettype wire

### rtl/core/cpd_back.sv
// Back part: chunk framing state machine and registered result stage.
// Depends on cpd_pkg.
`default_nettype none

module cpd_back #(
    parameter int SIZE_BITS = cpd_pkg::SIZE_BITS_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  cpd_pkg::item_t        head_item,
    input  wire logic             queue_empty,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [15:0]           m_axis_tdata,
    output logic                  m_axis_tuser,
    output cpd_pkg::back_status_t status
);
    import cpd_pkg::*;

    localparam logic [SIZE_BITS-1:0] ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

    logic [2:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] size_accum_reg, size_accum_next;
    logic                 digits_seen_reg, digits_seen_next;
    logic                 size_bad_reg, size_bad_next;
    logic                 in_ext_reg, in_ext_next;
    logic                 pending_cr_reg, pending_cr_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic                 finished_reg, finished_next;

    logic                 out_valid_reg;
    logic                 pv_reg, pv_next;
    logic [7:0]           pb_reg, pb_next;
    logic [2:0]           oc_reg, oc_next;

    logic                 lf_taken;

    assign pop           = !queue_empty && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = pv_reg;
    assign m_axis_tdata  = {5'd0, oc_reg, pb_reg};
    assign status        = '{phase: phase_reg, finished: finished_reg};

    always_comb begin
        phase_next       = phase_reg;
        size_accum_next  = size_accum_reg;
        digits_seen_next = digits_seen_reg;
        size_bad_next    = size_bad_reg;
        in_ext_next      = in_ext_reg;
        pending_cr_next  = pending_cr_reg;
        bytes_left_next  = bytes_left_reg;
        finished_next    = finished_reg;
        pv_next          = 1'b0;
        pb_next          = 8'd0;
        oc_next          = OC_PENDING;
        lf_taken         = 1'b0;

        if (!finished_reg) begin
            unique case (phase_reg) inside
                PH_HDR_START, PH_HDR: begin
                    phase_next = PH_HDR;
                    if (pending_cr_reg) begin
                        pending_cr_next = 1'b0;
                        if (head_item.is_lf) begin
                            lf_taken = 1'b1;
                            if (!digits_seen_reg || size_bad_reg) begin
                                oc_next = OC_INVALID;
                            end else if (size_accum_reg == '0) begin
                                oc_next = OC_COMPLETE;
                            end else begin
                                bytes_left_next  = size_accum_reg;
                                size_accum_next  = '0;
                                digits_seen_next = 1'b0;
                                size_bad_next    = 1'b0;
                                in_ext_next      = 1'b0;
                                phase_next       = PH_DATA;
                            end
                        end else if (!in_ext_reg) begin
                            size_bad_next = 1'b1;
                        end
                    end
                    if (!lf_taken) begin
                        if (head_item.is_cr) begin
                            pending_cr_next = 1'b1;
                        end else if (in_ext_reg) begin
                            in_ext_next = 1'b1;
                        end else if (head_item.is_semi) begin
                            in_ext_next = 1'b1;
                        end else begin
                            digits_seen_next = 1'b1;
                            if (!head_item.is_hex
                                || (size_accum_reg[SIZE_BITS-1 -: 4] != 4'd0)) begin
                                size_bad_next = 1'b1;
                            end else begin
                                size_accum_next = {size_accum_reg[SIZE_BITS-5:0],
                                                   head_item.hex_val};
                            end
                        end
                    end
                end
                PH_DATA: begin
                    pv_next         = 1'b1;
                    pb_next         = head_item.data;
                    bytes_left_next = bytes_left_reg - ONE;
                    if (bytes_left_reg == ONE) begin
                        phase_next = PH_TRAIL_CR;
                    end
                end
                PH_TRAIL_CR: begin
                    if (head_item.is_cr) begin
                        phase_next = PH_TRAIL_LF;
                    end else begin
                        oc_next = OC_TRUNCATED;
                    end
                end
                PH_TRAIL_LF: begin
                    if (head_item.is_lf) begin
                        phase_next = PH_HDR_START;
                    end else begin
                        oc_next = OC_TRUNCATED;
                    end
                end
                default: begin
                    phase_next = PH_HDR_START;
                end
            endcase

            if ((oc_next == OC_PENDING) && head_item.body_end) begin
                if (phase_next == PH_HDR_START) begin
                    oc_next = OC_NO_TERM;
                end else if (phase_next == PH_HDR) begin
                    oc_next = OC_MALFORMED;
                end else begin
                    oc_next = OC_TRUNCATED;
                end
            end
        end

        if (head_item.body_end) begin
            phase_next       = PH_HDR_START;
            size_accum_next  = '0;
            digits_seen_next = 1'b0;
            size_bad_next    = 1'b0;
            in_ext_next      = 1'b0;
            pending_cr_next  = 1'b0;
            bytes_left_next  = '0;
            finished_next    = 1'b0;
        end else if (oc_next != OC_PENDING) begin
            finished_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HDR_START;
            size_accum_reg  <= '0;
            digits_seen_reg <= 1'b0;
            size_bad_reg    <= 1'b0;
            in_ext_reg      <= 1'b0;
            pending_cr_reg  <= 1'b0;
            bytes_left_reg  <= '0;
            finished_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg       <= phase_next;
                size_accum_reg  <= size_accum_next;
                digits_seen_reg <= digits_seen_next;
                size_bad_reg    <= size_bad_next;
                in_ext_reg      <= in_ext_next;
                pending_cr_reg  <= pending_cr_next;
                bytes_left_reg  <= bytes_left_next;
                finished_reg    <= finished_next;
                out_valid_reg   <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            pv_reg <= pv_next;
            pb_reg <= pb_next;
            oc_reg <= oc_next;
        end
    end

endmodule

`default_nettype wire
